>>> hw/rtl/analog_comparator_with_irq_modes_assert.svh
// Assertion macros shared by the comparator RTL.
`ifndef ANALOG_COMPARATOR_WITH_IRQ_MODES_ASSERT_SVH
`define ANALOG_COMPARATOR_WITH_IRQ_MODES_ASSERT_SVH

// Checked at every clock edge outside reset.
`define ACMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ACMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/acmp_pkg.sv
`timescale 1ns / 1ps
package acmp_pkg;

  localparam int unsigned MUX_CHANNELS = 8;
  localparam int unsigned AdcDepth     = 16;
  localparam int unsigned AdcAddrW     = $clog2(AdcDepth);
  localparam int unsigned LevelW       = 16;
  localparam int unsigned ChannelW     = 5;
  localparam int unsigned CfgIndexW    = 3;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [ChannelW-1:0] ChAin0    = ChannelW'(0);
  localparam logic [ChannelW-1:0] ChAin1    = ChannelW'(1);
  localparam logic [ChannelW-1:0] ChAdcBase = ChannelW'(2);
  localparam logic [ChannelW-1:0] ChAdcLast = ChannelW'(2 + AdcDepth - 1);
  localparam logic [AdcAddrW:0]   MuxLimit  = (AdcAddrW + 1)'(MUX_CHANNELS);

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_TICK_ALT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    IRQ_TOGGLE  = 2'd0,
    IRQ_NONE    = 2'd1,
    IRQ_FALLING = 2'd2,
    IRQ_RISING  = 2'd3
  } irq_mode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_COMPARATOR_OFF   = 3'd0,
    CFG_BANDGAP_SELECT   = 3'd1,
    CFG_MUX_ENABLE       = 3'd2,
    CFG_ADC_ENABLED      = 3'd3,
    CFG_ADC_POWERED_DOWN = 3'd4,
    CFG_MUX_SELECT       = 3'd5,
    CFG_IRQ_MODE         = 3'd6,
    CFG_BANDGAP_LEVEL    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                comparator_off;
    logic                bandgap_select;
    logic                mux_enable;
    logic                adc_enabled;
    logic                adc_powered_down;
    logic [AdcAddrW-1:0] mux_select;
    irq_mode_e           irq_mode;
    logic [LevelW-1:0]   bandgap_level;
  } cfg_t;

  typedef struct packed {
    req_e                req_type;
    logic [ChannelW-1:0] channel;
    logic [LevelW-1:0]   level;
  } item_t;

  typedef struct packed {
    logic comparator_out;
    logic out_changed;
    logic irq_raise;
    logic irq_flag;
  } result_t;

endpackage

>>> hw/rtl/acmp_if.sv
`timescale 1ns / 1ps
interface acmp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  channel;
  logic [15:0] level;

  modport source (output valid, req_type, channel, level, input ready);
  modport sink (input valid, req_type, channel, level, output ready);
endinterface

interface acmp_out_if;
  logic valid;
  logic ready;
  logic comparator_out;
  logic out_changed;
  logic irq_raise;
  logic irq_flag;

  modport source (output valid, comparator_out, out_changed, irq_raise, irq_flag,
                  input ready);
  modport sink (input valid, comparator_out, out_changed, irq_raise, irq_flag,
                output ready);
endinterface

interface acmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/acmp_level_mem.sv
`timescale 1ns / 1ps
module acmp_level_mem
  import acmp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [AdcAddrW-1:0] wr_addr_i,
  input  logic [LevelW-1:0]   wr_data_i,
  input  logic [AdcAddrW-1:0] rd_addr_i,
  output logic [LevelW-1:0]   rd_data_o
);

  logic [LevelW-1:0]   mem [AdcDepth];
  logic [AdcDepth-1:0] written_q;
  logic [AdcDepth-1:0] written_d;
  logic [LevelW-1:0]   rd_q;
  logic                rd_vld_q;

  always_comb begin
    written_d = written_q;
    if (wr_en_i) begin
      written_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      written_q <= written_d;
      rd_vld_q  <= written_q[rd_addr_i];
    end
  end

  // An entry never written reads as its reset level of zero.
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

>>> hw/rtl/acmp_eval.sv
`timescale 1ns / 1ps
module acmp_eval
  import acmp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              acc_i,
  input  item_t             item_i,
  input  logic [LevelW-1:0] adc_rd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           result_o
);

  logic              s1_vld_q, s1_vld_d;
  item_t             s1_q;
  logic              s1_adv;
  logic [LevelW-1:0] ain_q [2];
  logic              out_bit_q, flag_q;
  logic              out_vld_q, out_vld_d;
  result_t           res_q;

  logic                is_upd, adc_ch, adc_hit, use_mux, now;
  logic                changed, raised, mode_ok, flag_base, out_bit_n, flag_n;
  logic [ChannelW-1:0] adc_off;
  logic [LevelW-1:0]   ain0_cur, ain1_cur, adc_cur, pos, neg;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_ready_o) begin
      s1_vld_d = acc_i;
    end
    out_vld_d = out_vld_q;
    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_comb begin
    is_upd   = (s1_q.req_type == REQ_UPDATE);
    adc_ch   = (s1_q.channel >= ChAdcBase) && (s1_q.channel <= ChAdcLast);
    adc_off  = s1_q.channel - ChAdcBase;
    adc_hit  = is_upd && adc_ch && (adc_off[AdcAddrW-1:0] == cfg_i.mux_select);
    ain0_cur = (is_upd && s1_q.channel == ChAin0) ? s1_q.level : ain_q[0];
    ain1_cur = (is_upd && s1_q.channel == ChAin1) ? s1_q.level : ain_q[1];
    adc_cur  = adc_hit ? s1_q.level : adc_rd_i;
    use_mux  = cfg_i.mux_enable && !cfg_i.adc_enabled && !cfg_i.adc_powered_down &&
               ({1'b0, cfg_i.mux_select} < MuxLimit);
    pos      = cfg_i.bandgap_select ? cfg_i.bandgap_level : ain0_cur;
    neg      = use_mux ? adc_cur : ain1_cur;
    now      = (pos > neg);
    changed  = !cfg_i.comparator_off && (now != out_bit_q);
    case (cfg_i.irq_mode)
      IRQ_TOGGLE:  mode_ok = 1'b1;
      IRQ_FALLING: mode_ok = !now;
      IRQ_RISING:  mode_ok = now;
      default:     mode_ok = 1'b0;
    endcase
    raised    = changed && mode_ok;
    flag_base = (s1_q.req_type == REQ_CLEAR) ? 1'b0 : flag_q;
    flag_n    = raised || flag_base;
    out_bit_n = changed ? now : out_bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      out_bit_q <= 1'b0;
      flag_q    <= 1'b0;
      ain_q[0]  <= '0;
      ain_q[1]  <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      if (s1_adv) begin
        out_bit_q <= out_bit_n;
        flag_q    <= flag_n;
        ain_q[0]  <= ain0_cur;
        ain_q[1]  <= ain1_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && acc_i) begin
      s1_q <= item_i;
    end
    if (s1_adv) begin
      res_q.comparator_out <= out_bit_n;
      res_q.out_changed    <= changed;
      res_q.irq_raise      <= raised;
      res_q.irq_flag       <= flag_n;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

endmodule

>>> hw/rtl/analog_comparator_with_irq_modes.sv
`timescale 1ns / 1ps
// Analog comparator with selectable interrupt edge. The block takes one item per clock unless
// a result held at the output stalls it, and passes each item through the evaluation stage, then
// the output register, which lets a new item in while a result waits. The sixteen ADC channel
// levels live in a memory that is read every cycle at the selected mux channel; an update to
// that channel still in the evaluation stage is forwarded past the memory. Entries read as zero
// until first written, so no clearing pass follows reset. Configuration writes complete at once.
`include "analog_comparator_with_irq_modes_assert.svh"
module analog_comparator_with_irq_modes
  import acmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  acmp_cfg_if.sink    cfg_i,
  acmp_in_if.sink     in_i,
  acmp_out_if.source  out_o
);

  cfg_t                cfg_q, cfg_d;
  item_t               item;
  logic                in_acc, wr_en;
  logic [ChannelW-1:0] wr_off;
  logic [LevelW-1:0]   adc_rd;
  result_t             res;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_COMPARATOR_OFF:   cfg_d.comparator_off   = cfg_i.data[0];
        CFG_BANDGAP_SELECT:   cfg_d.bandgap_select   = cfg_i.data[0];
        CFG_MUX_ENABLE:       cfg_d.mux_enable       = cfg_i.data[0];
        CFG_ADC_ENABLED:      cfg_d.adc_enabled      = cfg_i.data[0];
        CFG_ADC_POWERED_DOWN: cfg_d.adc_powered_down = cfg_i.data[0];
        CFG_MUX_SELECT:       cfg_d.mux_select       = cfg_i.data[AdcAddrW-1:0];
        CFG_IRQ_MODE:         cfg_d.irq_mode         = irq_mode_e'(cfg_i.data[1:0]);
        CFG_BANDGAP_LEVEL:    cfg_d.bandgap_level    = cfg_i.data[LevelW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.req_type = req_e'(in_i.req_type);
  assign item.channel  = in_i.channel;
  assign item.level    = in_i.level;
  assign in_acc        = in_i.valid && in_i.ready;

  assign wr_off = in_i.channel - ChAdcBase;
  assign wr_en  = in_acc && (item.req_type == REQ_UPDATE) &&
                  (in_i.channel >= ChAdcBase) && (in_i.channel <= ChAdcLast);

  acmp_level_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_off[AdcAddrW-1:0]),
    .wr_data_i (in_i.level),
    .rd_addr_i (cfg_q.mux_select),
    .rd_data_o (adc_rd)
  );

  acmp_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .acc_i       (in_i.valid),
    .item_i      (item),
    .adc_rd_i    (adc_rd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (res)
  );

  assign out_o.comparator_out = res.comparator_out;
  assign out_o.out_changed    = res.out_changed;
  assign out_o.irq_raise      = res.irq_raise;
  assign out_o.irq_flag       = res.irq_flag;

  `ACMP_ASSERT(a_raise_needs_edge,
               out_o.valid && out_o.irq_raise |-> out_o.out_changed,
               "interrupt raised without an output edge")
  `ACMP_ASSERT(a_raise_sets_flag,
               out_o.valid && out_o.irq_raise |-> out_o.irq_flag,
               "interrupt raised but flag clear")
  `ACMP_ASSERT(a_off_no_edge,
               out_o.valid && cfg_q.comparator_off |-> !out_o.out_changed,
               "edge reported while comparator is off")
  `ACMP_ASSERT_ALWAYS(a_reset_empty,
                      !rst_ni |=> !out_o.valid,
                      "result pending right after reset")

endmodule

>>> bench/analog_comparator_with_irq_modes_test.sv
`timescale 1ns / 1ps
module analog_comparator_with_irq_modes_test;
  import acmp_pkg::*;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    req_e                kind;
    logic [ChannelW-1:0] ch;
    logic [LevelW-1:0]   lvl;
    bit                  known;
    result_t             res;
  } plan_row_t;

  localparam int PlanLen = 45;
  localparam int Phases = 10;
  localparam int PhaseItems = 85;

  logic clk_i;
  logic rst_ni;

  acmp_cfg_if cfg_bus ();
  acmp_in_if  in_bus ();
  acmp_out_if out_bus ();

  analog_comparator_with_irq_modes u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Shadow of the comparator state and its registers.
  logic [LevelW-1:0] ain_lvl [2];
  logic [LevelW-1:0] adc_lvl [AdcDepth];
  logic              cmp_bit;
  logic              flag_bit;
  cfg_t              cfg_shadow;

  result_t expected_q [$];
  int      fail_count;
  bit      typed_known;
  result_t typed_res;
  bit      sender_burst;
  bit      rdy_state;
  int      rdy_left;

  plan_row_t plan [PlanLen] = '{
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b1, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin0, 16'hFFFF, 1'b1, 4'b1111},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin1, 16'hFFFF, 1'b1, 4'b0111},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_CLEAR, 5'd31, 16'hFFFF, 1'b1, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin1, 16'h0000, 1'b1, 4'b1111},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_CLEAR, ChAin0, 16'h0000, 1'b1, 4'b1000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, 5'd31, 16'hFFFF, 1'b1, 4'b1000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK_ALT, 5'd31, 16'hFFFF, 1'b1, 4'b1000},
    '{1'b1, CFG_IRQ_MODE, {14'h0000, IRQ_FALLING}, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin0, 16'h0000, 1'b1, 4'b0111},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_CLEAR, ChAin0, 16'h0000, 1'b1, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin0, 16'h0001, 1'b1, 4'b1100},
    '{1'b1, CFG_IRQ_MODE, {14'h0000, IRQ_RISING}, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin0, 16'h0000, 1'b1, 4'b0100},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin0, 16'h0001, 1'b1, 4'b1111},
    '{1'b1, CFG_IRQ_MODE, {14'h3FFF, IRQ_NONE}, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin1, 16'h0001, 1'b1, 4'b0101},
    '{1'b1, CFG_MUX_ENABLE, 16'h0001, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_MUX_SELECT, 16'h0007, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, 5'd9, 16'hFFFF, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, 5'd9, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_MUX_SELECT, 16'h0008, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAdcLast, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_MUX_SELECT, 16'hFFFF, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_COMPARATOR_OFF, 16'h0001, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_CLEAR, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_BANDGAP_SELECT, 16'h0001, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_BANDGAP_LEVEL, 16'hFFFF, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_ADC_ENABLED, 16'h0001, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_MUX_SELECT, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAdcBase, 16'hFFFF, 1'b0, 4'b0000},
    '{1'b1, CFG_ADC_ENABLED, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_ADC_POWERED_DOWN, 16'h0001, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_BANDGAP_LEVEL, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_ADC_POWERED_DOWN, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b0, CFG_COMPARATOR_OFF, 16'h0000, REQ_UPDATE, ChAdcBase, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_IRQ_MODE, {14'h0000, IRQ_TOGGLE}, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_BANDGAP_SELECT, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000},
    '{1'b1, CFG_MUX_ENABLE, 16'h0000, REQ_TICK, ChAin0, 16'h0000, 1'b0, 4'b0000}
  };

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  function automatic void apply_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_COMPARATOR_OFF:   cfg_shadow.comparator_off = data[0];
      CFG_BANDGAP_SELECT:   cfg_shadow.bandgap_select = data[0];
      CFG_MUX_ENABLE:       cfg_shadow.mux_enable = data[0];
      CFG_ADC_ENABLED:      cfg_shadow.adc_enabled = data[0];
      CFG_ADC_POWERED_DOWN: cfg_shadow.adc_powered_down = data[0];
      CFG_MUX_SELECT:       cfg_shadow.mux_select = data[AdcAddrW-1:0];
      CFG_IRQ_MODE:         cfg_shadow.irq_mode = irq_mode_e'(data[1:0]);
      CFG_BANDGAP_LEVEL:    cfg_shadow.bandgap_level = data[LevelW-1:0];
      default: ;
    endcase
  endfunction

  function automatic result_t compare_and_flag(req_e kind, logic [ChannelW-1:0] ch,
                                               logic [LevelW-1:0] lvl);
    result_t           r;
    logic [LevelW-1:0] pos;
    logic [LevelW-1:0] neg;
    logic              now;
    r = '0;
    if (kind == REQ_UPDATE) begin
      if (ch < ChAdcBase) begin
        ain_lvl[ch[0]] = lvl;
      end else if (ch <= ChAdcLast) begin
        adc_lvl[AdcAddrW'(ch - ChAdcBase)] = lvl;
      end
    end else if (kind == REQ_CLEAR) begin
      flag_bit = 1'b0;
    end
    if (!cfg_shadow.comparator_off) begin
      pos = cfg_shadow.bandgap_select ? cfg_shadow.bandgap_level : ain_lvl[0];
      neg = ain_lvl[1];
      if (cfg_shadow.mux_enable && !cfg_shadow.adc_enabled && !cfg_shadow.adc_powered_down &&
          int'(cfg_shadow.mux_select) < int'(MUX_CHANNELS)) begin
        neg = adc_lvl[cfg_shadow.mux_select];
      end
      now = (pos > neg);
      if (now != cmp_bit) begin
        cmp_bit = now;
        r.out_changed = 1'b1;
        if (cfg_shadow.irq_mode == IRQ_TOGGLE ||
            (cfg_shadow.irq_mode == IRQ_FALLING && !now) ||
            (cfg_shadow.irq_mode == IRQ_RISING && now)) begin
          r.irq_raise = 1'b1;
          flag_bit = 1'b1;
        end
      end
    end
    r.comparator_out = cmp_bit;
    r.irq_flag = flag_bit;
    return r;
  endfunction

  task automatic note_failure(string what, result_t want, result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected out=%0b chg=%0b irq=%0b flag=%0b, got out=%0b chg=%0b irq=%0b flag=%0b",
               $realtime, what, want.comparator_out, want.out_changed, want.irq_raise,
               want.irq_flag, got.comparator_out, got.out_changed, got.irq_raise, got.irq_flag);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_register(cfg_idx_e'(cfg_bus.index), cfg_bus.data);
      end
      if (in_bus.valid && in_bus.ready) begin
        want = compare_and_flag(req_e'(in_bus.req_type), in_bus.channel, in_bus.level);
        if (typed_known) begin
          want = typed_res;
        end
        expected_q.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        got.comparator_out = out_bus.comparator_out;
        got.out_changed = out_bus.out_changed;
        got.irq_raise = out_bus.irq_raise;
        got.irq_flag = out_bus.irq_flag;
        if (expected_q.size() == 0) begin
          note_failure("result with nothing pending", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.comparator_out !== want.comparator_out || got.out_changed !== want.out_changed ||
              got.irq_raise !== want.irq_raise || got.irq_flag !== want.irq_flag) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
    end
  end

  function automatic int short_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 2);
    end else if (r < 92) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (sender_burst || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return short_gap();
  endfunction

  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_state = !rdy_state;
      if (!rdy_state) begin
        rdy_left = short_gap();
      end else if ($urandom_range(0, 7) == 0) begin
        rdy_left = $urandom_range(100, 300);
      end else begin
        rdy_left = $urandom_range(1, 20);
      end
    end
    rdy_left--;
    out_bus.ready <= rdy_state;
  end

  task automatic send_item(req_e kind, logic [ChannelW-1:0] ch, logic [LevelW-1:0] lvl,
                           bit known, result_t res);
    int gap;
    gap = sender_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.req_type <= kind;
    in_bus.channel <= ch;
    in_bus.level <= lvl;
    typed_known <= known;
    typed_res <= res;
    @(posedge clk_i);
    while (!in_bus.ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
    logic [AdcAddrW-1:0] sel;
    req_e                kind;
    logic [ChannelW-1:0] ch;
    logic [LevelW-1:0]   lvl;
    int                  r;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = '0;
    in_bus.channel = '0;
    in_bus.level = '0;
    out_bus.ready = 1'b0;
    rdy_state = 1'b0;
    rdy_left = 0;
    typed_known = 1'b0;
    typed_res = '0;
    sender_burst = 1'b0;
    fail_count = 0;
    ain_lvl = '{default: '0};
    adc_lvl = '{default: '0};
    cmp_bit = 1'b0;
    flag_bit = 1'b0;
    cfg_shadow = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_for_idle();
        write_register(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].kind, plan[i].ch, plan[i].lvl, plan[i].known, plan[i].res);
      end
    end

    for (int phase = 0; phase < Phases; phase++) begin
      wait_for_idle();
      for (int i = 0; i < 8; i++) begin
        idx = cfg_idx_e'(i);
        r = $urandom_range(0, 99);
        case (idx)
          CFG_COMPARATOR_OFF:   data = {15'($urandom), 1'(r < 15)};
          CFG_BANDGAP_SELECT:   data = {15'($urandom), 1'(r < 50)};
          CFG_MUX_ENABLE:       data = {15'($urandom), 1'(r < 75)};
          CFG_ADC_ENABLED:      data = {15'($urandom), 1'(r < 25)};
          CFG_ADC_POWERED_DOWN: data = {15'($urandom), 1'(r < 25)};
          CFG_MUX_SELECT: begin
            if (r < 20) begin
              sel = '0;
            end else if (r < 40) begin
              sel = AdcAddrW'(MUX_CHANNELS - 1);
            end else if (r < 50) begin
              sel = AdcAddrW'(MUX_CHANNELS);
            end else if (r < 60) begin
              sel = '1;
            end else begin
              sel = AdcAddrW'($urandom);
            end
            data = {12'($urandom), sel};
          end
          CFG_IRQ_MODE:         data = {14'($urandom), 2'($urandom)};
          default: begin
            data = (r < 15) ? '0 : (r < 30) ? '1 : 16'($urandom);
          end
        endcase
        write_register(idx, data);
      end
      sender_burst = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) begin
        r = $urandom_range(0, 99);
        kind = (r < 60) ? REQ_UPDATE : (r < 75) ? REQ_CLEAR : (r < 95) ? REQ_TICK : REQ_TICK_ALT;
        ch = ChannelW'($urandom);
        lvl = LevelW'($urandom);
        if (kind == REQ_UPDATE) begin
          r = $urandom_range(0, 99);
          if (r < 30) begin
            ch = ChAin0;
          end else if (r < 55) begin
            ch = ChAin1;
          end else if (r < 75) begin
            ch = ChAdcBase + ChannelW'(cfg_shadow.mux_select);
          end else if (r < 92) begin
            ch = ChannelW'($urandom_range(ChAdcBase, ChAdcLast));
          end else begin
            ch = ChannelW'($urandom_range(ChAdcLast + 1, 31));
          end
          r = $urandom_range(0, 99);
          if (r < 10) begin
            lvl = '0;
          end else if (r < 20) begin
            lvl = '1;
          end else if (r < 50) begin
            case ($urandom_range(0, 2))
              0: lvl = ain_lvl[0];
              1: lvl = ain_lvl[1];
              default: lvl = cfg_shadow.bandgap_level;
            endcase
            lvl = lvl + LevelW'($urandom_range(0, 2)) - LevelW'(1);
          end
        end
        send_item(kind, ch, lvl, 1'b0, '0);
      end
    end

    wait_for_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("analog_comparator_with_irq_modes_test passed");
    end else begin
      $display("analog_comparator_with_irq_modes_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("analog_comparator_with_irq_modes_test failed");
    $finish;
  end

endmodule
